// ===== rtl/wct_pkg.sv =====
// ----------------------------------------------------------------------------
// wct_pkg: shared types and constants of the window correlation tracker
// Field widths, register codes, filter gains and the sequencer states.
// ----------------------------------------------------------------------------
package wct_pkg;

	// Field widths
	localparam int MAG_W   = 17;
	localparam int ACC_W   = 16;
	localparam int COEF_W  = 16;
	localparam int THR_W   = 15;
	localparam int CFG_W   = 17;
	localparam int WIN_W   = 7;
	localparam int IDX_W   = 2;
	localparam int IN_W    = 72;
	localparam int OUT_W   = 40;
	localparam int WIDE_W  = 64;
	localparam int ROOT_W  = 32;
	localparam int MUL_W   = 32;

	// Default window length
	localparam int WINDOW_SAMPLES_DEF = 64;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_COEF_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_SIG_LEVEL      = 2'd1;
	localparam logic [IDX_W-1:0] REG_WINDOW_FROM    = 2'd2;
	localparam logic [IDX_W-1:0] REG_WINDOW_TO      = 2'd3;

	// Register reset values
	localparam logic [THR_W-1:0] COEF_THRESHOLD_RST = 15'd26214;
	localparam logic [MAG_W-1:0] SIG_LEVEL_RST      = 17'd0;
	localparam logic [WIN_W-1:0] WINDOW_FROM_RST    = 7'd0;
	localparam logic [WIN_W-1:0] WINDOW_TO_RST      = 7'd32;

	// Filter gains in Q1.15: 0.10 rising, 0.01 falling
	localparam logic [MUL_W-1:0] GAIN_UP = 32'd3277;
	localparam logic [MUL_W-1:0] GAIN_DN = 32'd328;

	// Input opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_Z,
		ST_SQ_SUM,
		ST_MAG_ROOT,
		ST_LOAD,
		ST_COR_RD,
		ST_COR_AA,
		ST_COR_BB,
		ST_COR_AB,
		ST_COR_ACC,
		ST_VAR_LO,
		ST_VAR_HI,
		ST_VAR_SQ,
		ST_VAR_FIN,
		ST_VAR_CHK,
		ST_NORM,
		ST_ROOT,
		ST_DEN,
		ST_SHIFT,
		ST_CMP,
		ST_DIV,
		ST_FILT_MUL,
		ST_FILT_ADD,
		ST_SCAN_INIT,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/wct_isqrt.sv =====
// ----------------------------------------------------------------------------
// wct_isqrt: iterative integer square root
// Floor root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module wct_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wct_pkg::WIDE_W-1:0]   value,
	output logic                         done,
	output logic [wct_pkg::ROOT_W-1:0]   root
);
	import wct_pkg::*;

	logic [WIDE_W-1:0] v_q;
	logic [WIDE_W-1:0] r_q;
	logic [WIDE_W-1:0] b_q;
	logic              busy_q;
	logic              done_q;
	logic [WIDE_W-1:0] trial;

	// Trial subtrahend of the current step
	assign trial = r_q + b_q;

	// Control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == WIDE_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// One root bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
			b_q <= WIDE_W'(1) << (WIDE_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule

// ===== rtl/window_correlation_tracker.sv =====
// ----------------------------------------------------------------------------
// window_correlation_tracker: sliding-window Pearson correlation tracker
// Push words add a sample magnitude to window A, load words fill window B,
// and the last load correlates both windows and, unless a variance is zero,
// updates a smoothed coefficient. Every word gives one result word.
// ----------------------------------------------------------------------------
// Sequence: a push squares the axes and takes a root, a load writes window B,
//   and each then runs the motion check over its slot range; a last load
//   also forms the window sums, the variances, two roots and the division.
// Throughput: one word at a time; the shared multiplier and root unit set it.
// Reset: control state and registers go to defaults; window A reads as zero
//   through a fill count, so there is no clearing pass.
module window_correlation_tracker #(
	parameter int WINDOW_SAMPLES = wct_pkg::WINDOW_SAMPLES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// s_tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32],
	//          ref_magnitude[64:48], zero fill
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [wct_pkg::IN_W-1:0]    s_tdata,
	input  logic                        s_tuser,  // opcode
	input  logic                        s_tlast,  // ref_last
	// m_tdata: sample_magnitude[16:0], smoothed_coef[32:17], coef_updated[33],
	//          above_coef_threshold[34], significant_motion[35], zero fill
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [wct_pkg::OUT_W-1:0]   m_tdata,
	input  logic                        cfg_we,
	input  logic [wct_pkg::IDX_W-1:0]   cfg_index,
	input  logic [wct_pkg::CFG_W-1:0]   cfg_data
);
	import wct_pkg::*;

	localparam int AW     = $clog2(WINDOW_SAMPLES);
	localparam int IW     = (AW + 1 > WIN_W) ? AW + 1 : WIN_W;
	localparam int SUM_W  = MAG_W + AW;
	localparam int SQ_W   = 2 * MAG_W + AW;
	localparam logic [AW:0]      N_PTR = (AW + 1)'(WINDOW_SAMPLES);
	localparam logic [IW-1:0]    N_IW  = IW'(WINDOW_SAMPLES);
	localparam logic [MUL_W-1:0] N_MUL = MUL_W'(WINDOW_SAMPLES);
	localparam logic [WIDE_W-1:0] NORM_LIMIT = WIDE_W'(1) << 60;

	// Configuration registers
	logic [THR_W-1:0] coef_threshold_q;
	logic [MAG_W-1:0] sig_level_q;
	logic [WIN_W-1:0] window_from_q;
	logic [WIN_W-1:0] window_to_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_threshold_q <= COEF_THRESHOLD_RST;
			sig_level_q      <= SIG_LEVEL_RST;
			window_from_q    <= WINDOW_FROM_RST;
			window_to_q      <= WINDOW_TO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_THRESHOLD: coef_threshold_q <= cfg_data[THR_W-1:0];
				REG_SIG_LEVEL:      sig_level_q      <= cfg_data[MAG_W-1:0];
				REG_WINDOW_FROM:    window_from_q    <= cfg_data[WIN_W-1:0];
				REG_WINDOW_TO:      window_to_q      <= cfg_data[WIN_W-1:0];
				default:            coef_threshold_q <= coef_threshold_q;
			endcase
		end
	end

	// Sequencer and datapath registers
	state_t state_q, state_d;

	logic                   last_q;
	logic [ACC_W-1:0]       ax_q, ay_q, az_q;
	logic [MAG_W-1:0]       ref_mag_q;
	logic [MAG_W-1:0]       mag_q;
	logic [AW-1:0]          wp_q;
	logic [AW:0]            fill_q;
	logic [AW-1:0]          ref_idx_q;
	logic [IW-1:0]          cnt_q;
	logic [MAG_W-1:0]       a_q, b_q;
	logic [SUM_W-1:0]       sa_q, sb_q;
	logic [SQ_W-1:0]        saa_q, sbb_q, sab_q;
	logic [1:0]             k_q;
	logic [WIDE_W-1:0]      acc_q;
	logic [WIDE_W-1:0]      va_q, vb_q, r0_q;
	logic [WIDE_W-1:0]      nv_q;
	logic                   sel_q;
	logic [WIN_W-1:0]       e_q;
	logic [ROOT_W-1:0]      root_a_q;
	logic [WIDE_W-1:0]      num_q;
	logic [COEF_W-1:0]      q_q;
	logic [3:0]             dcnt_q;
	logic                   dneg_q;
	logic signed [COEF_W-1:0] cf_q;
	logic                   upd_q;
	logic                   sig_q;
	logic                   m_valid_q;
	logic [OUT_W-1:0]       m_data_q;
	logic [WIDE_W-1:0]      prod_q;

	// Memories
	logic [MAG_W-1:0] mem_a [WINDOW_SAMPLES];
	logic [MAG_W-1:0] mem_b [WINDOW_SAMPLES];
	logic [MAG_W-1:0] a_rd_q, b_rd_q;

	// Combinational control
	logic              accept;
	logic              mul_en;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic              sq_start;
	logic [WIDE_W-1:0] sq_val;
	logic              sq_done;
	logic [ROOT_W-1:0] sq_root;
	logic              a_we;
	logic              b_we;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Absolute values of the axes
	logic [MAG_W-1:0] ax_ext, ay_ext, az_ext;
	logic [MAG_W-1:0] ax_abs, ay_abs, az_abs;
	assign ax_ext = {ax_q[ACC_W-1], ax_q};
	assign ay_ext = {ay_q[ACC_W-1], ay_q};
	assign az_ext = {az_q[ACC_W-1], az_q};
	assign ax_abs = ax_ext[MAG_W-1] ? (~ax_ext + MAG_W'(1)) : ax_ext;
	assign ay_abs = ay_ext[MAG_W-1] ? (~ay_ext + MAG_W'(1)) : ay_ext;
	assign az_abs = az_ext[MAG_W-1] ? (~az_ext + MAG_W'(1)) : az_ext;

	// Logical slot to physical address of window A
	logic [AW:0]   phys_sum;
	logic [AW-1:0] a_addr;
	assign phys_sum = {1'b0, wp_q} + {1'b0, cnt_q[AW-1:0]};
	assign a_addr   = (phys_sum >= N_PTR) ? AW'(phys_sum - N_PTR) : phys_sum[AW-1:0];

	// Slots not yet pushed read as zero
	logic             a_ok;
	logic [MAG_W-1:0] a_val;
	assign a_ok  = cnt_q >= (N_IW - IW'(fill_q));
	assign a_val = a_ok ? a_rd_q : '0;

	// Operands of the current sum term
	logic [WIDE_W-1:0] term_sq;
	logic [MUL_W-1:0]  term_u, term_v;
	always_comb begin
		case (k_q)
			2'd0: begin
				term_sq = WIDE_W'(saa_q);
				term_u  = MUL_W'(sa_q);
				term_v  = MUL_W'(sa_q);
			end
			2'd1: begin
				term_sq = WIDE_W'(sbb_q);
				term_u  = MUL_W'(sb_q);
				term_v  = MUL_W'(sb_q);
			end
			default: begin
				term_sq = WIDE_W'(sab_q);
				term_u  = MUL_W'(sa_q);
				term_v  = MUL_W'(sb_q);
			end
		endcase
	end

	// Raw coefficient, saturated, and the filter difference
	logic                    r_neg;
	logic signed [MAG_W-1:0] r_val;
	logic signed [MAG_W:0]   delta;
	logic [MAG_W:0]          delta_abs;
	logic                    rising;
	assign r_neg = r0_q[WIDE_W-1];
	always_comb begin
		if (r_neg) begin
			r_val = -$signed({1'b0, q_q});
		end else if (q_q[COEF_W-1]) begin
			r_val = MAG_W'(32767);
		end else begin
			r_val = $signed({1'b0, q_q});
		end
	end
	assign delta     = {r_val[MAG_W-1], r_val} - {{2{cf_q[COEF_W-1]}}, cf_q};
	assign delta_abs = delta[MAG_W] ? (~delta + (MAG_W + 1)'(1)) : delta;
	assign rising    = $signed(r_val) > $signed({cf_q[COEF_W-1], cf_q});

	// Motion check bound
	logic [IW-1:0] scan_hi;
	assign scan_hi = (IW'(window_to_q) < N_IW) ? IW'(window_to_q) : N_IW;

	// Filter step, rounded half away from zero
	logic [COEF_W-1:0] fstep;
	assign fstep = COEF_W'((prod_q + WIDE_W'(16384)) >> 15);

	logic out_free;
	assign out_free = !m_valid_q || m_tready;

	// Next state and control strobes
	always_comb begin
		state_d  = state_q;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		sq_start = 1'b0;
		sq_val   = nv_q;
		a_we     = 1'b0;
		b_we     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == OP_LOAD) ? ST_LOAD : ST_SQ_X;
				end
			end
			ST_SQ_X: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(ax_abs);
				mul_b   = MUL_W'(ax_abs);
				state_d = ST_SQ_Y;
			end
			ST_SQ_Y: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(ay_abs);
				mul_b   = MUL_W'(ay_abs);
				state_d = ST_SQ_Z;
			end
			ST_SQ_Z: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(az_abs);
				mul_b   = MUL_W'(az_abs);
				state_d = ST_SQ_SUM;
			end
			ST_SQ_SUM: begin
				sq_start = 1'b1;
				sq_val   = acc_q + prod_q;
				state_d  = ST_MAG_ROOT;
			end
			ST_MAG_ROOT: begin
				if (sq_done) begin
					a_we    = 1'b1;
					state_d = ST_SCAN_INIT;
				end
			end
			ST_LOAD: begin
				b_we    = 1'b1;
				state_d = last_q ? ST_COR_RD : ST_SCAN_INIT;
			end
			ST_COR_RD: state_d = ST_COR_AA;
			ST_COR_AA: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(a_val);
				mul_b   = MUL_W'(a_val);
				state_d = ST_COR_BB;
			end
			ST_COR_BB: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(b_q);
				mul_b   = MUL_W'(b_q);
				state_d = ST_COR_AB;
			end
			ST_COR_AB: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(a_q);
				mul_b   = MUL_W'(b_q);
				state_d = ST_COR_ACC;
			end
			ST_COR_ACC: begin
				state_d = (cnt_q == N_IW - IW'(1)) ? ST_VAR_LO : ST_COR_RD;
			end
			ST_VAR_LO: begin
				mul_en  = 1'b1;
				mul_a   = term_sq[MUL_W-1:0];
				mul_b   = N_MUL;
				state_d = ST_VAR_HI;
			end
			ST_VAR_HI: begin
				mul_en  = 1'b1;
				mul_a   = term_sq[WIDE_W-1:MUL_W];
				mul_b   = N_MUL;
				state_d = ST_VAR_SQ;
			end
			ST_VAR_SQ: begin
				mul_en  = 1'b1;
				mul_a   = term_u;
				mul_b   = term_v;
				state_d = ST_VAR_FIN;
			end
			ST_VAR_FIN: begin
				state_d = (k_q == 2'd2) ? ST_VAR_CHK : ST_VAR_LO;
			end
			ST_VAR_CHK: begin
				state_d = (va_q == '0 || vb_q == '0) ? ST_SCAN_INIT : ST_NORM;
			end
			ST_NORM: begin
				if (nv_q >= NORM_LIMIT) begin
					sq_start = 1'b1;
					state_d  = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (sq_done) begin
					state_d = sel_q ? ST_DEN : ST_NORM;
				end
			end
			ST_DEN: begin
				mul_en  = 1'b1;
				mul_a   = root_a_q;
				mul_b   = sq_root;
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (e_q == '0) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: state_d = (num_q >= prod_q) ? ST_FILT_MUL : ST_DIV;
			ST_DIV: begin
				if (dcnt_q == 4'd14) begin
					state_d = ST_FILT_MUL;
				end
			end
			ST_FILT_MUL: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(delta_abs);
				mul_b   = rising ? GAIN_UP : GAIN_DN;
				state_d = ST_FILT_ADD;
			end
			ST_FILT_ADD: state_d = ST_SCAN_INIT;
			ST_SCAN_INIT: begin
				state_d = (IW'(window_from_q) >= scan_hi) ? ST_DONE : ST_SCAN_RD;
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				state_d = (cnt_q + IW'(1) >= scan_hi) ? ST_DONE : ST_SCAN_RD;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Shared multiplier with registered product
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= WIDE_W'(mul_a) * WIDE_W'(mul_b);
		end
	end

	// Shared root unit
	wct_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_val),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Window memories with registered reads
	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[wp_q] <= sq_root[MAG_W-1:0];
		end
		a_rd_q <= mem_a[a_addr];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			mem_b[ref_idx_q] <= ref_mag_q;
		end
		b_rd_q <= mem_b[cnt_q[AW-1:0]];
	end

	// Control registers: pointers, filter state, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			fill_q    <= '0;
			ref_idx_q <= '0;
			cf_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (a_we) begin
				wp_q <= (wp_q == AW'(WINDOW_SAMPLES - 1)) ? '0 : wp_q + AW'(1);
				if (fill_q != N_PTR) begin
					fill_q <= fill_q + (AW + 1)'(1);
				end
			end
			if (b_we) begin
				if (last_q || ref_idx_q == AW'(WINDOW_SAMPLES - 1)) begin
					ref_idx_q <= '0;
				end else begin
					ref_idx_q <= ref_idx_q + AW'(1);
				end
			end
			if (state_q == ST_FILT_ADD) begin
				cf_q <= dneg_q ? cf_q - $signed(fstep) : cf_q + $signed(fstep);
			end
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ax_q      <= s_tdata[15:0];
					ay_q      <= s_tdata[31:16];
					az_q      <= s_tdata[47:32];
					ref_mag_q <= s_tdata[64:48];
					last_q    <= s_tlast;
					mag_q     <= '0;
					upd_q     <= 1'b0;
				end
			end
			ST_SQ_Y: acc_q <= prod_q;
			ST_SQ_Z: acc_q <= acc_q + prod_q;
			ST_MAG_ROOT: begin
				if (sq_done) begin
					mag_q <= sq_root[MAG_W-1:0];
				end
			end
			ST_LOAD: begin
				cnt_q <= '0;
				sa_q  <= '0;
				sb_q  <= '0;
				saa_q <= '0;
				sbb_q <= '0;
				sab_q <= '0;
				k_q   <= 2'd0;
			end
			ST_COR_AA: begin
				a_q <= a_val;
				b_q <= b_rd_q;
			end
			ST_COR_BB: saa_q <= saa_q + SQ_W'(prod_q);
			ST_COR_AB: sbb_q <= sbb_q + SQ_W'(prod_q);
			ST_COR_ACC: begin
				sab_q <= sab_q + SQ_W'(prod_q);
				sa_q  <= sa_q + SUM_W'(a_q);
				sb_q  <= sb_q + SUM_W'(b_q);
				cnt_q <= cnt_q + IW'(1);
			end
			ST_VAR_HI: acc_q <= prod_q;
			ST_VAR_SQ: acc_q <= acc_q + (prod_q << MUL_W);
			ST_VAR_FIN: begin
				case (k_q)
					2'd0:    va_q <= acc_q - prod_q;
					2'd1:    vb_q <= acc_q - prod_q;
					default: r0_q <= acc_q - prod_q;
				endcase
				k_q <= k_q + 2'd1;
			end
			ST_VAR_CHK: begin
				nv_q  <= va_q;
				sel_q <= 1'b0;
				e_q   <= '0;
			end
			ST_NORM: begin
				if (nv_q < NORM_LIMIT) begin
					nv_q <= nv_q << 2;
					e_q  <= e_q + WIN_W'(1);
				end
			end
			ST_ROOT: begin
				// Keep the root of window A; the root of window B stays on the unit.
				if (sq_done && !sel_q) begin
					root_a_q <= sq_root;
					nv_q     <= vb_q;
					sel_q    <= 1'b1;
				end
			end
			ST_DEN: num_q <= r_neg ? (~r0_q + WIDE_W'(1)) : r0_q;
			ST_SHIFT: begin
				if (e_q != '0) begin
					num_q <= num_q << 1;
					e_q   <= e_q - WIN_W'(1);
				end
			end
			ST_CMP: begin
				q_q    <= (num_q >= prod_q) ? COEF_W'(32768) : '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				if ((num_q << 1) >= prod_q) begin
					num_q <= (num_q << 1) - prod_q;
					q_q   <= {q_q[COEF_W-2:0], 1'b1};
				end else begin
					num_q <= num_q << 1;
					q_q   <= {q_q[COEF_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 4'd1;
			end
			ST_FILT_MUL: dneg_q <= delta[MAG_W];
			ST_FILT_ADD: upd_q <= 1'b1;
			ST_SCAN_INIT: begin
				sig_q <= 1'b0;
				cnt_q <= IW'(window_from_q);
			end
			ST_SCAN_CHK: begin
				if (a_val > sig_level_q) begin
					sig_q <= 1'b1;
				end
				cnt_q <= cnt_q + IW'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					m_data_q <= {4'b0, sig_q,
						$signed(cf_q) >= $signed({1'b0, coef_threshold_q}),
						upd_q, cf_q, mag_q};
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Checks on internal invariants
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= N_PTR)
		else $error("window A fill count beyond window length");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> num_q < prod_q)
		else $error("division remainder not below divisor");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAG_ROOT && sq_done) |-> sq_root[ROOT_W-1:MAG_W] == '0)
		else $error("sample magnitude root out of range");

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("new word taken while one is in work");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for window_correlation_tracker
// Drives push and load words with random gaps, predicts every result word
// from a behavioral copy of the windows, the filter and the registers, and
// compares each result word field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import wct_pkg::*;

typedef struct {
	logic [16:0]        magnitude;
	logic signed [15:0] coef;
	logic               updated;
	logic               above;
	logic               motion;
} tracker_result_t;

class tracker_scoreboard;
	int unsigned        win_a [64];
	int unsigned        win_b [64];
	int unsigned        load_slot;
	int                 coef_state;
	int unsigned        thr_reg, level_reg, from_reg, to_reg;
	tracker_result_t    awaited [$];
	int                 errors;

	function new();
		foreach (win_a[i]) begin
			win_a[i] = 0;
			win_b[i] = 0;
		end
		load_slot  = 0;
		coef_state = 0;
		thr_reg    = 26214;
		level_reg  = 0;
		from_reg   = 0;
		to_reg     = 32;
		errors     = 0;
	endfunction

	function void write_reg(logic [IDX_W-1:0] idx, int unsigned value);
		case (idx)
			REG_COEF_THRESHOLD: thr_reg = value & 32'h7FFF;
			REG_SIG_LEVEL:      level_reg = value & 32'h1FFFF;
			REG_WINDOW_FROM:    from_reg = value & 32'h7F;
			REG_WINDOW_TO:      to_reg = value & 32'h7F;
			default: ;
		endcase
	endfunction

	// Bitwise integer square root, floor result.
	function longint unsigned root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Normalize a variance into [2^60, 2^62) and return its root and shift.
	function longint unsigned norm_root(longint unsigned v, output int shift);
		shift = 0;
		while (v < (64'd1 << 60)) begin
			v <<= 2;
			shift++;
		end
		return root64(v);
	endfunction

	// Pearson coefficient of both windows in Q1.15; 0 when undefined.
	function bit pearson(output int r);
		longint unsigned sa, sb, sab, saa, sbb, va, vb, den, num, rem, q;
		longint r0;
		int ma, mb;
		sa = 0; sb = 0; sab = 0; saa = 0; sbb = 0;
		for (int i = 0; i < 64; i++) begin
			sa  += win_a[i];
			sb  += win_b[i];
			sab += longint'(win_a[i]) * win_b[i];
			saa += longint'(win_a[i]) * win_a[i];
			sbb += longint'(win_b[i]) * win_b[i];
		end
		va = 64 * saa - sa * sa;
		vb = 64 * sbb - sb * sb;
		r = 0;
		if (va == 0 || vb == 0) return 0;
		r0  = longint'(64 * sab) - longint'(sa * sb);
		den = norm_root(va, ma);
		den = den * norm_root(vb, mb);
		num = (r0 < 0) ? -r0 : r0;
		rem = num << (ma + mb);
		if (rem >= den) begin
			q = 32768;
		end else begin
			q = 0;
			for (int i = 0; i < 15; i++) begin
				rem <<= 1;
				q <<= 1;
				if (rem >= den) begin
					rem -= den;
					q |= 1;
				end
			end
		end
		if (r0 < 0) r = -int'(q);
		else r = (q > 32767) ? 32767 : int'(q);
		return 1;
	endfunction

	// Asymmetric low-pass step with round-half-away-from-zero.
	function void smooth(int r);
		int delta, gain, step;
		longint p;
		longint unsigned mag;
		delta = r - coef_state;
		gain  = (r > coef_state) ? int'(GAIN_UP) : int'(GAIN_DN);
		p     = longint'(delta) * gain;
		mag   = (p < 0) ? -p : p;
		step  = int'((mag + 16384) >> 15);
		coef_state += (p < 0) ? -step : step;
	endfunction

	// Note one accepted input word and queue the result word it causes.
	function void note_word(logic op, logic [IN_W-1:0] data, logic last);
		tracker_result_t res;
		int x, y, z, r, hi;
		longint unsigned sq;
		res.magnitude = 0;
		res.updated   = 0;
		if (op == OP_PUSH) begin
			x  = $signed(data[15:0]);
			y  = $signed(data[31:16]);
			z  = $signed(data[47:32]);
			sq = longint'(x * x) + longint'(y * y) + longint'(z * z);
			res.magnitude = root64(sq);
			for (int i = 0; i < 63; i++) win_a[i] = win_a[i + 1];
			win_a[63] = res.magnitude;
		end else begin
			win_b[load_slot] = data[64:48];
			load_slot = (load_slot + 1) % 64;
			if (last) begin
				load_slot = 0;
				if (pearson(r)) begin
					smooth(r);
					res.updated = 1;
				end
			end
		end
		res.coef   = coef_state;
		res.above  = coef_state >= int'(thr_reg);
		res.motion = 0;
		hi = (to_reg < 64) ? to_reg : 64;
		for (int i = from_reg; i < hi; i++)
			if (win_a[i] > level_reg) res.motion = 1;
		awaited.push_back(res);
	endfunction

	// Compare one result word with the oldest expectation.
	function void check_word(logic [OUT_W-1:0] word);
		tracker_result_t e;
		if (awaited.size() == 0) begin
			$error("result word 0x%h arrived with nothing expected", word);
			errors++;
			return;
		end
		e = awaited.pop_front();
		if (word[16:0] !== e.magnitude) begin
			$error("sample_magnitude: expected %0d, got %0d", e.magnitude, word[16:0]);
			errors++;
		end
		if (word[32:17] !== e.coef) begin
			$error("smoothed_coef: expected %0d, got %0d", e.coef, $signed(word[32:17]));
			errors++;
		end
		if (word[33] !== e.updated) begin
			$error("coef_updated: expected %0b, got %0b", e.updated, word[33]);
			errors++;
		end
		if (word[34] !== e.above) begin
			$error("above_coef_threshold: expected %0b, got %0b", e.above, word[34]);
			errors++;
		end
		if (word[35] !== e.motion) begin
			$error("significant_motion: expected %0b, got %0b", e.motion, word[35]);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                s_tuser;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	tracker_scoreboard   sb;
	bit                  hold_output;
	int                  words_sent;

	window_correlation_tracker DUT (.*);

	// Clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly short gaps, a few long ones.
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Send one word, wait for acceptance, then idle for a random gap.
	task automatic send_word(logic op, logic [15:0] ax, logic [15:0] ay,
			logic [15:0] az, logic [16:0] refm, logic last);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tlast  <= last;
		s_tdata  <= {7'd0, refm, az, ay, ax};
		do @(posedge clk); while (!s_tready);
		sb.note_word(op, {7'd0, refm, az, ay, ax}, last);
		words_sent++;
		@(negedge clk);
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic push_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
		send_word(OP_PUSH, ax, ay, az, 17'($urandom), 1'($urandom));
	endtask

	task automatic load_ref(logic [16:0] refm, logic last);
		send_word(OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), refm, last);
	endtask

	// Let the block drain: stop sending and wait for every awaited result.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	// Reference value: random, mirrored, or tracking window A so that high coefficients occur.
	function automatic logic [16:0] ref_value();
		int unsigned v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 131071);
			1: v = 131071 - (sb.win_a[sb.load_slot] % 131072);
			default: v = sb.win_a[sb.load_slot] + $urandom_range(0, 300);
		endcase
		return (v > 131071) ? 17'd131071 : 17'(v);
	endfunction

	// Acceleration axis with extremes and small values mixed in.
	function automatic logic [15:0] axis();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3, 4: return 16'($urandom_range(0, 2000) - 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	// Output side: random stalls, one long hold-off on request.
	initial begin
		int stall;
		m_tready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_output = 0;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 4) == 0) stall = gap_len();
			end
		end
	end

	// Result checking at the rising edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata);
	end

	// Run limit.
	initial begin
		#50ms;
		$display("Some tests failed");
		$finish;
	end

	// Stimulus.
	initial begin
		int unsigned thr_set   [5] = '{0, 32767, 100, 16384, 26214};
		int unsigned level_set [5] = '{131071, 0, 2000, 500, 5000};
		int unsigned from_set  [5] = '{64, 0, 10, 63, 40};
		int unsigned to_set    [5] = '{0, 64, 64, 5, 20};
		int phase, len;
		sb          = new();
		hold_output = 0;
		words_sent  = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_PUSH;
		s_tlast     = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_COEF_THRESHOLD;
		cfg_data    = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: axis extremes and zero.
		push_sample(16'h8000, 16'h8000, 16'h8000);
		push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
		push_sample(16'h0000, 16'h0000, 16'h0000);
		push_sample(16'h8000, 16'h7FFF, 16'h0001);
		push_sample(16'hFFFF, 16'h0000, 16'h0003);
		push_sample(16'h0003, 16'h0004, 16'h0000);
		// Constant reference window: zero variance, no update.
		for (int i = 0; i < 64; i++) load_ref(17'd131071, i == 63);
		// Full pass without last wraps the slot index, then an early last.
		for (int i = 0; i < 64; i++) load_ref((i % 2) ? 17'd131071 : 17'd0, 1'b0);
		for (int i = 0; i < 5; i++) load_ref(17'(i * 1000), i == 4);
		// Fresh B pass tracking A for a defined coefficient.
		for (int i = 0; i < 64; i++) load_ref(ref_value(), i == 63);

		// Random part: push bursts and reference passes, settings per phase.
		for (phase = 0; phase < 5; phase++) begin
			drain();
			write_reg(REG_COEF_THRESHOLD, thr_set[phase]);
			write_reg(REG_SIG_LEVEL, level_set[phase]);
			write_reg(REG_WINDOW_FROM, from_set[phase]);
			write_reg(REG_WINDOW_TO, to_set[phase]);
			for (int n = 0; n < 120; ) begin
				if (phase == 2 && n == 0) hold_output = 1;
				len = $urandom_range(1, 20);
				for (int k = 0; k < len; k++) push_sample(axis(), axis(), axis());
				n += len;
				len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 70) : 64;
				for (int k = 0; k < len; k++)
					load_ref(ref_value(), (k == len - 1) ? 1'($urandom_range(0, 5) != 0) :
						($urandom_range(0, 40) == 0));
				n += len;
			end
		end

		// Wait for every result, then a short quiet period.
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/wct_pkg.sv
rtl/wct_isqrt.sv
rtl/window_correlation_tracker.sv
sim/testbench.sv
